/* hdl/asphd_pkg.sv */
// Shared constants and types for the ambient-subtracting photo detector.
// No dependencies; used by asphd_core and the top level.
package asphd_pkg;

    // Default widths for the top level parameters.
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF  = 16;

    // Fixed widths of the configuration registers.
    localparam int THRESH_BITS = 10;
    localparam int SETTLE_BITS = 8;
    localparam int HOLD_BITS   = 16;
    localparam int PHASE_BITS  = 3;

    // Configuration port.
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_DETECT_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SETTLE_TICKS     = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HOLD_TICKS       = 2'd2;

    // Register values after reset.
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 10'd200;
    localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = 8'd1;
    localparam logic [HOLD_BITS-1:0]   HOLD_RESET   = 16'd500;

    // Result beat is five bits, padded to one byte.
    localparam int M_TDATA_BITS = 8;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic                  emitter_on;
        logic                  detected;
    } step_result_t;

endpackage

/* hdl/asphd_core.sv */
// Sequencer state and one-tick step logic of the photo detector.
// Depends on asphd_pkg.
module asphd_core #(
    parameter int SAMPLE_BITS = asphd_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = asphd_pkg::COUNT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_en,
    input  logic [SAMPLE_BITS-1:0]              adc_sample,
    input  logic                                rearm,
    input  logic [SAMPLE_BITS-1:0]              thresh,
    input  logic [asphd_pkg::SETTLE_BITS-1:0]   settle_ticks,
    input  logic [asphd_pkg::HOLD_BITS-1:0]     hold_ticks,
    output asphd_pkg::step_result_t             result
);

    typedef enum logic [asphd_pkg::PHASE_BITS-1:0] {
        PH_INIT   = 3'd0,
        PH_EMIT   = 3'd1,
        PH_SETTLE = 3'd2,
        PH_LIT    = 3'd3,
        PH_DARK   = 3'd4,
        PH_DETECT = 3'd5,
        PH_HOLD   = 3'd6,
        PH_REARM  = 3'd7
    } phase_t;

    localparam int LOAD_BITS = (COUNT_BITS > asphd_pkg::HOLD_BITS) ?
                               COUNT_BITS : asphd_pkg::HOLD_BITS;
    localparam logic [LOAD_BITS-1:0] COUNT_MAX = LOAD_BITS'({COUNT_BITS{1'b1}});

    phase_t                 phase_reg, phase_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [SAMPLE_BITS-1:0] lit_reg, lit_next;
    logic                   rearm_reg, rearm_next;
    logic                   emit_reg, emit_next;
    logic                   detected;
    logic                   rearm_seen;
    logic                   count_done;

    // A zero count behaves as one; a count above the counter range saturates.
    function automatic logic [COUNT_BITS-1:0] load_count(
        input logic [asphd_pkg::HOLD_BITS-1:0] v
    );
        logic [LOAD_BITS-1:0] ext;
        ext = LOAD_BITS'(v);
        if (ext == '0) begin
            ext = LOAD_BITS'(1);
        end
        if (ext > COUNT_MAX) begin
            ext = COUNT_MAX;
        end
        return COUNT_BITS'(ext);
    endfunction

    assign rearm_seen = rearm_reg | rearm;
    assign count_done = (count_reg <= COUNT_BITS'(1));

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        lit_next   = lit_reg;
        rearm_next = rearm_seen;
        emit_next  = emit_reg;
        detected   = 1'b0;
        case (phase_reg)
            PH_INIT: begin
                phase_next = PH_EMIT;
            end
            PH_EMIT: begin
                emit_next  = 1'b1;
                count_next = load_count(asphd_pkg::HOLD_BITS'(settle_ticks));
                phase_next = PH_SETTLE;
            end
            PH_SETTLE: begin
                if (count_done) begin
                    count_next = '0;
                    phase_next = PH_LIT;
                end else begin
                    count_next = count_reg - COUNT_BITS'(1);
                end
            end
            PH_LIT: begin
                lit_next   = adc_sample;
                emit_next  = 1'b0;
                phase_next = PH_DARK;
            end
            PH_DARK: begin
                // Unsigned difference, guarded: a dark reading above the lit one never detects.
                if ((lit_reg >= adc_sample) && ((lit_reg - adc_sample) >= thresh)) begin
                    phase_next = PH_DETECT;
                end else begin
                    phase_next = PH_EMIT;
                end
            end
            PH_DETECT: begin
                detected   = 1'b1;
                count_next = load_count(hold_ticks);
                phase_next = PH_HOLD;
            end
            PH_HOLD: begin
                if (count_done) begin
                    count_next = '0;
                    phase_next = PH_REARM;
                end else begin
                    count_next = count_reg - COUNT_BITS'(1);
                end
            end
            PH_REARM: begin
                if (rearm_seen) begin
                    rearm_next = 1'b0;
                    phase_next = PH_INIT;
                end
            end
            default: begin
                phase_next = PH_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_INIT;
            count_reg <= '0;
            lit_reg   <= '0;
            rearm_reg <= 1'b0;
            emit_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            lit_reg   <= lit_next;
            rearm_reg <= rearm_next;
            emit_reg  <= emit_next;
        end
    end

    assign result.detected   = detected;
    assign result.emitter_on = emit_next;
    assign result.phase      = phase_next;

    // The emitter is lit exactly while waiting to take the lit sample.
    a_emit_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SETTLE || phase_reg == PH_LIT) |-> emit_reg)
        else $error("emitter off during settle or lit sample");

    a_emit_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DETECT || phase_reg == PH_HOLD || phase_reg == PH_REARM
         || phase_reg == PH_DARK || phase_reg == PH_INIT) |-> !emit_reg)
        else $error("emitter lit outside the lit window");

    // A detection step always enters the hold wait with a nonzero count.
    a_hold_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && phase_reg == PH_DETECT) |=> (phase_reg == PH_HOLD && count_reg != '0))
        else $error("hold wait entered without a count");

    // A rearm request is never dropped before the await phase consumes it.
    a_rearm_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && rearm && phase_reg != PH_REARM) |=> rearm_reg)
        else $error("rearm request lost");

endmodule

/* hdl/ambient_subtracting_photo_detector_unit.sv */
// Top level of the ambient-subtracting photo detector: stream ports,
// configuration registers and the result buffer. Depends on asphd_pkg, asphd_core.
//
//   Channel   Direction  Beat contents (lowest bit first)
//   s_axis    in         adc_sample, rearm
//   m_axis    out        detected, emitter_on, phase
//   cfg       in         detect_threshold / settle_ticks / hold_ticks writes
//
// Every accepted input beat is one sequencer tick and yields exactly one result
// beat. The step is computed in the cycle the beat is accepted and registered in
// the output register, or in the skid while the output stalls; one beat per cycle
// is sustained while m_axis_tready is high. A two-entry result buffer (output
// register plus skid register) keeps s_axis_tready high while one result waits;
// tready drops only when both entries are full. Reset (aresetn low, synchronous)
// returns the sequencer to the init phase with the emitter off, clears any latched
// rearm request, empties the result buffer and restores the register defaults.
module ambient_subtracting_photo_detector_unit #(
    parameter int SAMPLE_BITS = asphd_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = asphd_pkg::COUNT_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // tdata: adc_sample [SAMPLE_BITS-1:0], rearm [SAMPLE_BITS], zero padding above
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+8)/8)*8-1:0]      s_axis_tdata,

    // tdata: detected [0], emitter_on [1], phase [4:2], zero padding above
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [asphd_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,

    input  logic                                  cfg_wr_en,
    input  logic [asphd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [asphd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    // The threshold register is further narrowed when samples are narrow.
    localparam int THR_BITS = (SAMPLE_BITS < asphd_pkg::THRESH_BITS) ?
                              SAMPLE_BITS : asphd_pkg::THRESH_BITS;
    localparam int PAD_BITS = asphd_pkg::M_TDATA_BITS - $bits(asphd_pkg::step_result_t);

    logic [THR_BITS-1:0]                thresh_reg;
    logic [asphd_pkg::SETTLE_BITS-1:0]  settle_reg;
    logic [asphd_pkg::HOLD_BITS-1:0]    hold_reg;

    logic                     out_valid_reg;
    asphd_pkg::step_result_t  out_data_reg;
    logic                     skid_valid_reg;
    asphd_pkg::step_result_t  skid_data_reg;

    logic                     in_fire;
    logic                     out_fire;
    asphd_pkg::step_result_t  step_result;

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THR_BITS'(asphd_pkg::THRESH_RESET);
            settle_reg <= asphd_pkg::SETTLE_RESET;
            hold_reg   <= asphd_pkg::HOLD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                asphd_pkg::REG_DETECT_THRESHOLD: begin
                    thresh_reg <= cfg_wdata[THR_BITS-1:0];
                end
                asphd_pkg::REG_SETTLE_TICKS: begin
                    settle_reg <= cfg_wdata[asphd_pkg::SETTLE_BITS-1:0];
                end
                asphd_pkg::REG_HOLD_TICKS: begin
                    hold_reg <= cfg_wdata[asphd_pkg::HOLD_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    asphd_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (in_fire),
        .adc_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .rearm        (s_axis_tdata[SAMPLE_BITS]),
        .thresh       (SAMPLE_BITS'(thresh_reg)),
        .settle_ticks (settle_reg),
        .hold_ticks   (hold_reg),
        .result       (step_result)
    );

    // Result buffer. A new result goes to the output register when that register
    // is empty or being drained this cycle, otherwise into the skid register.
    // The skid entry moves forward when the output register drains; no input is
    // accepted in that cycle because tready is low while the skid is full.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (out_fire) begin
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (in_fire) begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_data_reg  <= step_result;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_data_reg  <= step_result;
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_fire) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_BITS{1'b0}}, out_data_reg};

    // The skid entry is only ever filled behind a waiting output beat.
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // Each accepted beat produces a result the following cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

    // A stalled output with a new beat accepted must park it in the skid.
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("result dropped while output stalled");

endmodule
